@@ src/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, muted while reset is high.
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same, with the clock and reset named at the point of use.
`define ASSERT_PROP_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

@@ src/bis_pkg.sv @@
`timescale 1ns / 1ps

package bis_pkg;

   localparam int OP_W   = 3;
   localparam int ELEM_W = 8;
   localparam int CNT_W  = 9;

   localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
   localparam logic [OP_W-1:0] OP_MEMBER     = 3'd2;
   localparam logic [OP_W-1:0] OP_SUCCESSOR  = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPLEMENT = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the request
      logic exec;       // first pass: check range, single-word update or full clear
      logic scan;       // one word of the successor search
      logic sweep;      // one word of the complement pass
      logic finish;     // load the response register
      logic csr_write;  // top_element write
   } bis_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scan;
      logic need_sweep;
      logic scan_done;
      logic sweep_last;
      logic rsp_free;
   } bis_status_type;

endpackage

@@ src/bis_ctrl.sv @@
`timescale 1ns / 1ps

module bis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    csr_valid,
   input  bis_pkg::bis_status_type status,
   output bis_pkg::bis_cmd_type    cmd,
   output logic                    req_stall,
   output logic                    csr_ready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.csr_write = csr_valid;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_scan) begin
               state_in = S_SCAN;
            end else if (status.need_sweep) begin
               state_in = S_SWEEP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/bis_datapath.sv @@
`timescale 1ns / 1ps

module bis_datapath #(
   parameter int SET_SIZE = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bis_pkg::bis_cmd_type     cmd,
   output bis_pkg::bis_status_type  status,
   input  logic [bis_pkg::OP_W-1:0]   req_op,
   input  logic [bis_pkg::ELEM_W-1:0] req_element,
   input  logic [bis_pkg::ELEM_W-1:0] csr_top_element,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic                     rsp_is_member,
   output logic [bis_pkg::ELEM_W-1:0] rsp_next_element,
   output logic                     rsp_next_valid,
   output logic [bis_pkg::CNT_W-1:0]  rsp_member_count,
   output logic [bis_pkg::ELEM_W-1:0] rsp_smallest_member,
   output logic                     rsp_smallest_valid,
   output logic                     rsp_range_error
);

   // Only elements 0..255 are reachable, so storage stops there.
   localparam int BITS   = (SET_SIZE < 256) ? SET_SIZE : 256;
   localparam int WORD_W = (BITS < 32) ? BITS : 32;
   localparam int NWORDS = (BITS + WORD_W - 1) / WORD_W;
   localparam int BW_W   = $clog2(WORD_W);
   localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam logic [bis_pkg::ELEM_W-1:0] MAX_TOP = bis_pkg::ELEM_W'(BITS - 1);
   localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NWORDS - 1);

   function automatic logic [BW_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
      logic [BW_W-1:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            idx = BW_W'(i);
         end
      end
      return idx;
   endfunction

   logic [WORD_W-1:0]  words_ff [NWORDS];
   logic [WORD_W-1:0]  words_in [NWORDS];
   logic [bis_pkg::OP_W-1:0]   op_ff, op_in;
   logic [bis_pkg::ELEM_W-1:0] elem_ff, elem_in;
   logic [bis_pkg::ELEM_W-1:0] top_ff, top_in;
   logic [bis_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [bis_pkg::ELEM_W-1:0] small_ff, small_in;
   logic                       known_ff, known_in;
   logic                       err_ff, err_in;
   logic [bis_pkg::ELEM_W-1:0] next_ff, next_in;
   logic                       next_valid_ff, next_valid_in;
   logic [WA_W-1:0]            ptr_ff, ptr_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_member_ff;
   logic [bis_pkg::ELEM_W-1:0] rsp_next_ff;
   logic                       rsp_next_valid_ff;
   logic [bis_pkg::CNT_W-1:0]  rsp_count_ff;
   logic [bis_pkg::ELEM_W-1:0] rsp_small_ff;
   logic                       rsp_small_valid_ff;
   logic                       rsp_err_ff;

   logic [bis_pkg::ELEM_W-1:0] eff_top;
   logic                       in_range;
   logic                       err_now;
   logic [WA_W-1:0]            e_word, top_word, rd_addr;
   logic [BW_W-1:0]            e_bit, top_bit;
   logic [WORD_W-1:0]          rd_word, onehot, gt_mask, le_mask;
   logic [WORD_W-1:0]          scan_word, sweep_mask, sweep_word, ffs_src;
   logic                       cur_bit, scan_found, last_scan;
   logic [BW_W-1:0]            ffs_idx;
   logic [bis_pkg::ELEM_W-1:0] found_elem;
   logic                       small_hit;

   assign eff_top  = (top_ff > MAX_TOP) ? MAX_TOP : top_ff;
   assign in_range = (elem_ff <= eff_top);
   assign err_now  = (op_ff <= bis_pkg::OP_SUCCESSOR) && !in_range;
   assign e_word   = WA_W'(elem_ff >> BW_W);
   assign e_bit    = elem_ff[BW_W-1:0];
   assign top_word = WA_W'(eff_top >> BW_W);
   assign top_bit  = eff_top[BW_W-1:0];

   assign rd_addr = (cmd.scan || cmd.sweep) ? ptr_ff : e_word;
   assign rd_word = words_ff[rd_addr];
   assign cur_bit = rd_word[e_bit];

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         onehot[i]  = (BW_W'(i) == e_bit);
         gt_mask[i] = (BW_W'(i) > e_bit);
         le_mask[i] = (BW_W'(i) <= top_bit);
      end
   end

   // successor search: bits above the element, at or below the top
   assign scan_word = rd_word & ((ptr_ff == e_word) ? gt_mask : '1)
                              & ((ptr_ff == top_word) ? le_mask : '1);
   assign scan_found = |scan_word;
   assign last_scan  = (ptr_ff == top_word);

   // complement: invert inside 0..top, drop everything above
   always_comb begin
      if (ptr_ff < top_word) begin
         sweep_mask = '1;
      end else if (ptr_ff == top_word) begin
         sweep_mask = le_mask;
      end else begin
         sweep_mask = '0;
      end
   end
   assign sweep_word = ~rd_word & sweep_mask;

   assign ffs_src    = cmd.sweep ? sweep_word : scan_word;
   assign ffs_idx    = lowest_set(ffs_src);
   assign found_elem = bis_pkg::ELEM_W'(bis_pkg::ELEM_W'(ptr_ff) * bis_pkg::ELEM_W'(WORD_W)
                                        + bis_pkg::ELEM_W'(ffs_idx));

   assign small_hit = known_ff && (small_ff == elem_ff);

   assign status.need_scan  = !err_now && cur_bit && (elem_ff < eff_top) &&
                              ((op_ff == bis_pkg::OP_SUCCESSOR) ||
                               ((op_ff == bis_pkg::OP_REMOVE) && small_hit));
   assign status.need_sweep = (op_ff == bis_pkg::OP_COMPLEMENT);
   assign status.scan_done  = scan_found || last_scan;
   assign status.sweep_last = (ptr_ff == LAST_WORD);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      words_in      = words_ff;
      op_in         = op_ff;
      elem_in       = elem_ff;
      top_in        = top_ff;
      count_in      = count_ff;
      small_in      = small_ff;
      known_in      = known_ff;
      err_in        = err_ff;
      next_in       = next_ff;
      next_valid_in = next_valid_ff;
      ptr_in        = ptr_ff;

      if (cmd.csr_write) begin
         top_in = csr_top_element;
      end

      if (cmd.load) begin
         op_in   = req_op;
         elem_in = req_element;
      end

      if (cmd.exec) begin
         err_in        = err_now;
         next_in       = '0;
         next_valid_in = 1'b0;
         ptr_in        = e_word;
         if (!err_now) begin
            unique case (op_ff)
               bis_pkg::OP_INSERT: begin
                  words_in[e_word] = rd_word | onehot;
                  count_in = count_ff + {{(bis_pkg::CNT_W-1){1'b0}}, ~cur_bit};
                  if (!known_ff || (small_ff > elem_ff)) begin
                     small_in = elem_ff;
                     known_in = 1'b1;
                  end
               end
               bis_pkg::OP_REMOVE: begin
                  words_in[e_word] = rd_word & ~onehot;
                  count_in = count_ff - {{(bis_pkg::CNT_W-1){1'b0}}, cur_bit};
                  if (small_hit && !status.need_scan) begin
                     known_in = 1'b0;
                     small_in = '0;
                  end
               end
               bis_pkg::OP_COMPLEMENT: begin
                  count_in = '0;
                  known_in = 1'b0;
                  small_in = '0;
                  ptr_in   = '0;
               end
               bis_pkg::OP_CLEAR: begin
                  for (int w = 0; w < NWORDS; w++) begin
                     words_in[w] = '0;
                  end
                  count_in = '0;
                  known_in = 1'b0;
                  small_in = '0;
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.scan) begin
         if (op_ff == bis_pkg::OP_REMOVE) begin
            if (scan_found) begin
               small_in = found_elem;
            end else if (last_scan) begin
               known_in = 1'b0;
               small_in = '0;
            end
         end else if (scan_found) begin
            next_in       = found_elem;
            next_valid_in = 1'b1;
         end
         if (!status.scan_done) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end

      if (cmd.sweep) begin
         words_in[ptr_ff] = sweep_word;
         count_in = count_ff + bis_pkg::CNT_W'($countones(sweep_word));
         if (!known_ff && (|sweep_word)) begin
            known_in = 1'b1;
            small_in = found_elem;
         end
         if (!status.sweep_last) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NWORDS; w++) begin
            words_ff[w] <= '0;
         end
         top_ff       <= '1;
         count_ff     <= '0;
         small_ff     <= '0;
         known_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         words_ff     <= words_in;
         top_ff       <= top_in;
         count_ff     <= count_in;
         small_ff     <= small_in;
         known_ff     <= known_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      elem_ff       <= elem_in;
      err_ff        <= err_in;
      next_ff       <= next_in;
      next_valid_ff <= next_valid_in;
      ptr_ff        <= ptr_in;
      if (cmd.finish) begin
         rsp_member_ff      <= !err_ff && in_range && cur_bit;
         rsp_next_ff        <= next_valid_ff ? next_ff : '0;
         rsp_next_valid_ff  <= next_valid_ff;
         rsp_count_ff       <= count_ff;
         rsp_small_ff       <= known_ff ? small_ff : '0;
         rsp_small_valid_ff <= known_ff;
         rsp_err_ff         <= err_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_member       = rsp_member_ff;
   assign rsp_next_element    = rsp_next_ff;
   assign rsp_next_valid      = rsp_next_valid_ff;
   assign rsp_member_count    = rsp_count_ff;
   assign rsp_smallest_member = rsp_small_ff;
   assign rsp_smallest_valid  = rsp_small_valid_ff;
   assign rsp_range_error     = rsp_err_ff;

endmodule

@@ src/bitmap_integer_set.sv @@
// Insert, member test, clear and misses pass capture, the update step and the response
//   register load; successor and remove-of-smallest add a word-by-word search of the bitmap.
// Complement adds a pass over every bitmap word (8 words of 32 bits at SET_SIZE 256).
// Items are handled one at a time; the next request is taken the cycle after the response
//   register loads.
// Reset (synchronous, active high) empties the set at once and sets top_element to 255.
`timescale 1ns / 1ps

module bitmap_integer_set #(
   parameter int SET_SIZE = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_element,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_member,
   output logic [7:0] rsp_next_element,
   output logic       rsp_next_valid,
   output logic [8:0] rsp_member_count,
   output logic [7:0] rsp_smallest_member,
   output logic       rsp_smallest_valid,
   output logic       rsp_range_error,
   // top_element register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_top_element
);

   // The controller sequences each item: capture, a single-word update or a full clear,
   // then an optional word-by-word successor search or complement pass, then the response
   // register load. The datapath holds the bitmap as an array of words, the count,
   // the smallest member and one priority encoder shared by search and complement.
   bis_pkg::bis_cmd_type    cmd;
   bis_pkg::bis_status_type status;

   bis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .csr_ready (csr_ready)
   );

   // The response register lets a finished result wait while the next request
   // is taken and worked on.
   bis_datapath #(
      .SET_SIZE (SET_SIZE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_op              (req_op),
      .req_element         (req_element),
      .csr_top_element     (csr_top_element),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_is_member       (rsp_is_member),
      .rsp_next_element    (rsp_next_element),
      .rsp_next_valid      (rsp_next_valid),
      .rsp_member_count    (rsp_member_count),
      .rsp_smallest_member (rsp_smallest_member),
      .rsp_smallest_valid  (rsp_smallest_valid),
      .rsp_range_error     (rsp_range_error)
   );

endmodule

@@ src/bis_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bis_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_member,
   input logic [7:0] rsp_next_element,
   input logic       rsp_next_valid,
   input logic [8:0] rsp_member_count,
   input logic [7:0] rsp_smallest_member,
   input logic       rsp_smallest_valid,
   input logic       rsp_range_error
);

   // a rejected element changes nothing and reports no membership or successor
   `ASSERT_PROP(a_err_quiet, rsp_valid && rsp_range_error |-> !rsp_is_member && !rsp_next_valid, "range error with member or successor flag")

   // a successor exists only for an element that is a member
   `ASSERT_PROP(a_next_member, rsp_valid && rsp_next_valid |-> rsp_is_member, "successor reported for a non-member")

   // a recorded smallest member implies a nonzero count
   `ASSERT_PROP(a_small_count, rsp_valid && rsp_smallest_valid |-> rsp_member_count != 9'd0, "smallest member with empty count")

   // a stalled response holds
   `ASSERT_PROP(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_member_count) && $stable(rsp_smallest_member), "stalled response changed")

endmodule

bind bitmap_integer_set bis_checker u_bis_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for bitmap_integer_set.
// A short directed table walks the corner cases. Some rows carry their
// response written in by hand, the rest are predicted. Ten random phases
// follow, each writing top_element first. Both channels idle at random. One
// phase holds the response side off for a long stretch, and another drains
// the block in mid-stream.
module tb;

   // op codes the block does not define; it must leave the set alone
   localparam logic [bis_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [bis_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer at all before giving up
   localparam int HOLD_CYCLES  = 60;    // long response hold-off
   localparam int TAIL_CYCLES  = 20;    // idle tail after the last response, with margin
   localparam int PHASE_ITEMS  = 140;
   localparam int REPORT_LIMIT = 10;

   // response fields in port order
   typedef struct packed {
      logic                       is_member;
      logic [bis_pkg::ELEM_W-1:0] next_element;
      logic                       next_valid;
      logic [bis_pkg::CNT_W-1:0]  member_count;
      logic [bis_pkg::ELEM_W-1:0] smallest_member;
      logic                       smallest_valid;
      logic                       range_error;
   } set_status_type;

   typedef struct {
      logic [bis_pkg::OP_W-1:0]   op;
      logic [bis_pkg::ELEM_W-1:0] element;
      set_status_type             status;
   } pending_type;

   typedef enum logic {ROW_REQ, ROW_TOP} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [bis_pkg::OP_W-1:0]   op;
      logic [bis_pkg::ELEM_W-1:0] value;   // element, or the new top for ROW_TOP
      bit                         typed;   // response written into the row
      set_status_type             status;
   } dir_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_op = '0;
   logic [7:0]        req_element = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_is_member;
   logic [7:0]        rsp_next_element;
   logic              rsp_next_valid;
   logic [8:0]        rsp_member_count;
   logic [7:0]        rsp_smallest_member;
   logic              rsp_smallest_valid;
   logic              rsp_range_error;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_top_element = '0;

   // predictor state: our own copy of the set
   logic [255:0]               set_bits;
   logic [bis_pkg::CNT_W-1:0]  set_count;
   logic [bis_pkg::ELEM_W-1:0] least_member;
   logic                       least_known;
   logic [bis_pkg::ELEM_W-1:0] top_limit;

   pending_type       pending_status [$];

   // idling knobs, changed per phase
   int                send_gap_max = 15;
   int                recv_gap_max = 15;
   bit                hold_pending = 1'b0;
   int                stall_left = 0;
   int                hold_left = 0;

   // run statistics
   int                mismatches = 0;
   int                responses_checked = 0;
   int                range_errors_seen = 0;
   int                successor_hits = 0;
   int                top_writes = 0;
   int                op_count [8];

   bitmap_integer_set uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_element         (req_element),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_is_member       (rsp_is_member),
      .rsp_next_element    (rsp_next_element),
      .rsp_next_valid      (rsp_next_valid),
      .rsp_member_count    (rsp_member_count),
      .rsp_smallest_member (rsp_smallest_member),
      .rsp_smallest_valid  (rsp_smallest_valid),
      .rsp_range_error     (rsp_range_error),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_top_element     (csr_top_element)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Next member above e up to the top; -1 when e is absent, at or above the top, or has none above it.
   function automatic int next_member_above(input logic [bis_pkg::ELEM_W-1:0] e);
      int j;
      if (!set_bits[e] || e >= top_limit) return -1;
      for (j = int'(e) + 1; j <= int'(top_limit); j++)
         if (set_bits[j]) return j;
      return -1;
   endfunction

   // Applies one operation to the predicted set and returns the status
   // the block should report for it.
   function automatic set_status_type apply_set_op(input logic [bis_pkg::OP_W-1:0] op,
                                                   input logic [bis_pkg::ELEM_W-1:0] e);
      set_status_type s;
      int             nxt;
      int             i;
      logic           in_range;
      s = '0;
      in_range = (e <= top_limit);
      // only the element-addressed ops are range checked
      if (!in_range && (op == bis_pkg::OP_INSERT || op == bis_pkg::OP_REMOVE ||
                        op == bis_pkg::OP_MEMBER || op == bis_pkg::OP_SUCCESSOR)) begin
         s.range_error = 1'b1;
      end else begin
         case (op)
            bis_pkg::OP_INSERT: begin
               if (!least_known || least_member > e) begin
                  least_member = e;
                  least_known = 1'b1;
               end
               if (!set_bits[e]) set_count = set_count + 1'b1;
               set_bits[e] = 1'b1;
            end
            bis_pkg::OP_REMOVE: begin
               // losing the smallest moves it up to its successor
               if (least_known && least_member == e) begin
                  nxt = next_member_above(e);
                  if (nxt < 0) begin
                     least_known = 1'b0;
                     least_member = '0;
                  end else begin
                     least_member = 8'(nxt);
                  end
               end
               if (set_bits[e]) set_count = set_count - 1'b1;
               set_bits[e] = 1'b0;
            end
            bis_pkg::OP_SUCCESSOR: begin
               nxt = next_member_above(e);
               if (nxt >= 0) begin
                  s.next_valid = 1'b1;
                  s.next_element = 8'(nxt);
               end
            end
            bis_pkg::OP_COMPLEMENT: begin
               // flips 0..top, drops anything above, then recounts
               set_count = '0;
               least_known = 1'b0;
               least_member = '0;
               for (i = 0; i < 256; i++) begin
                  if (i <= int'(top_limit)) begin
                     set_bits[i] = ~set_bits[i];
                     if (set_bits[i]) begin
                        if (!least_known) begin
                           least_known = 1'b1;
                           least_member = 8'(i);
                        end
                        set_count = set_count + 1'b1;
                     end
                  end else begin
                     set_bits[i] = 1'b0;
                  end
               end
            end
            bis_pkg::OP_CLEAR: begin
               set_bits = '0;
               set_count = '0;
               least_member = '0;
               least_known = 1'b0;
            end
            default: ;  // member test and spare codes change nothing
         endcase
      end
      s.is_member = !s.range_error && in_range && set_bits[e];
      s.member_count = set_count;
      s.smallest_member = least_known ? least_member : '0;
      s.smallest_valid = least_known;
      return s;
   endfunction

   function automatic set_status_type status_of(input int mem, input int nxt, input int nv,
                                                input int cnt, input int sm, input int sv,
                                                input int err);
      status_of = {1'(mem), 8'(nxt), 1'(nv), 9'(cnt), 8'(sm), 1'(sv), 1'(err)};
   endfunction

   // ------------------------------------------------------------------
   // Random item choice
   // ------------------------------------------------------------------

   function automatic logic [bis_pkg::OP_W-1:0] choose_op();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 34) return bis_pkg::OP_INSERT;
      if (roll < 54) return bis_pkg::OP_REMOVE;
      if (roll < 67) return bis_pkg::OP_MEMBER;
      if (roll < 88) return bis_pkg::OP_SUCCESSOR;
      if (roll < 93) return bis_pkg::OP_COMPLEMENT;
      if (roll < 96) return bis_pkg::OP_CLEAR;
      return (roll < 98) ? OP_SPARE_A : OP_SPARE_B;
   endfunction

   // Leans toward current members so successor and remove-of-smallest
   // see real work, with a share of out-of-range and edge elements.
   function automatic logic [bis_pkg::ELEM_W-1:0] choose_element(
         input logic [bis_pkg::OP_W-1:0] op);
      int unsigned roll;
      int unsigned start;
      int unsigned j;
      roll = $urandom_range(0, 99);
      if (op == bis_pkg::OP_COMPLEMENT || op == bis_pkg::OP_CLEAR ||
          op == OP_SPARE_A || op == OP_SPARE_B)
         return 8'($urandom_range(0, 255));
      if (roll < 15 && least_known) return least_member;
      if (roll < 40) begin
         start = $urandom_range(0, top_limit);
         for (j = start; j <= top_limit; j++)
            if (set_bits[j]) return 8'(j);
      end
      if (roll < 52 && top_limit < 8'd255)
         return 8'($urandom_range(int'(top_limit) + 1, 255));
      if (roll < 58) return roll[0] ? top_limit : 8'd0;
      return 8'($urandom_range(0, top_limit));
   endfunction

   // ------------------------------------------------------------------
   // Request and register drivers
   // ------------------------------------------------------------------

   // Offers one request after a random gap and holds it until the transfer.
   // The prediction is pushed at the transfer, so it always sees the state
   // left by the items before it.
   task automatic send_request(input logic [bis_pkg::OP_W-1:0] op,
                               input logic [bis_pkg::ELEM_W-1:0] e,
                               input bit typed, input set_status_type typed_status);
      int             gap;
      pending_type    entry;
      set_status_type predicted;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_element <= e;
      do @(posedge clock); while (req_stall);
      predicted = apply_set_op(op, e);
      entry.op = op;
      entry.element = e;
      entry.status = typed ? typed_status : predicted;
      pending_status.push_back(entry);
      op_count[op]++;
   endtask

   // Drops valid and waits until every predicted response has come back.
   // Always waits on the clock before returning so a following request never
   // gets two assignments to req_valid in one step.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   // Every item yields exactly one response, so once the queue is empty
   // the block is idle and the register may be written.
   task automatic write_top(input logic [bis_pkg::ELEM_W-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_top_element <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      top_limit = value;
      top_writes++;
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls plus the long hold-off
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (hold_pending) begin
            hold_left = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         // a new wait is drawn after every transfer
         if (rsp_valid && !rsp_stall) stall_left = $urandom_range(0, recv_gap_max);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every transfer against the oldest prediction
   // ------------------------------------------------------------------

   always @(posedge clock) begin : response_check
      set_status_type got;
      pending_type    want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = {rsp_is_member, rsp_next_element, rsp_next_valid, rsp_member_count,
                rsp_smallest_member, rsp_smallest_valid, rsp_range_error};
         responses_checked++;
         if (got.range_error) range_errors_seen++;
         if (got.next_valid) successor_hits++;
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR %0t: response transfer with nothing outstanding", $realtime);
         end else begin
            want = pending_status.pop_front();
            if (got !== want.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("ERROR %0t: op %0d element %0d", $realtime, want.op, want.element);
                  $display("   expected mem %0d next %0d/%0d count %0d least %0d/%0d err %0d",
                           want.status.is_member, want.status.next_element,
                           want.status.next_valid, want.status.member_count,
                           want.status.smallest_member, want.status.smallest_valid,
                           want.status.range_error);
                  $display("   actual   mem %0d next %0d/%0d count %0d least %0d/%0d err %0d",
                           got.is_member, got.next_element, got.next_valid,
                           got.member_count, got.smallest_member, got.smallest_valid,
                           got.range_error);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transfer on any channel ends the run
   // ------------------------------------------------------------------

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("ERROR: no transfer for %0d cycles, %0d responses still outstanding",
               IDLE_LIMIT, pending_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   initial begin : stimulus
      dir_row_type    directed_rows [27];
      set_status_type none;
      int             phase_tops [10];
      int             phase;
      int             k;
      int             saved_gap;
      logic [bis_pkg::OP_W-1:0] op;

      none = '0;
      foreach (op_count[n]) op_count[n] = 0;

      // predictor starts from the reset state
      set_bits = '0;
      set_count = '0;
      least_member = '0;
      least_known = 1'b0;
      top_limit = 8'd255;

      // Corner cases. Typed rows read straight off the rules; zero-status
      // rows with typed=0 are predicted. Starts at the reset top of 255.
      directed_rows = '{
         // empty set right after reset
         '{ROW_REQ, bis_pkg::OP_MEMBER,     8'd0,   1'b1, status_of(0, 0,   0, 0,   0,   0, 0)},
         // both ends of the element range
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd255, 1'b1, status_of(1, 0,   0, 1,   255, 1, 0)},
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd0,   1'b1, status_of(1, 0,   0, 2,   0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_SUCCESSOR,  8'd0,   1'b1, status_of(1, 255, 1, 2,   0,   1, 0)},
         // successor of the top finds nothing
         '{ROW_REQ, bis_pkg::OP_SUCCESSOR,  8'd255, 1'b1, status_of(1, 0,   0, 2,   0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd0,   1'b0, none},   // already present
         '{ROW_REQ, bis_pkg::OP_SUCCESSOR,  8'd7,   1'b0, none},   // not a member
         '{ROW_REQ, bis_pkg::OP_REMOVE,     8'd0,   1'b0, none},   // smallest moves to 255
         '{ROW_REQ, bis_pkg::OP_REMOVE,     8'd255, 1'b0, none},   // set empties
         '{ROW_REQ, OP_SPARE_A,             8'd3,   1'b0, none},
         // complement of the empty set fills all 256
         '{ROW_REQ, bis_pkg::OP_COMPLEMENT, 8'd0,   1'b1, status_of(1, 0,   0, 256, 0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_REMOVE,     8'd0,   1'b0, none},
         '{ROW_REQ, OP_SPARE_B,             8'd255, 1'b0, none},
         '{ROW_REQ, bis_pkg::OP_CLEAR,      8'd9,   1'b1, status_of(0, 0,   0, 0,   0,   0, 0)},
         '{ROW_TOP, bis_pkg::OP_INSERT,     8'd10,  1'b0, none},
         // just above the top
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd11,  1'b1, status_of(0, 0,   0, 0,   0,   0, 1)},
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd10,  1'b0, none},
         // complement over 0..10 with 10 set; element above top reads 0
         '{ROW_REQ, bis_pkg::OP_COMPLEMENT, 8'd200, 1'b1, status_of(0, 0,   0, 10,  0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_SUCCESSOR,  8'd9,   1'b0, none},
         // top lowered without a clear: stale members are still counted
         '{ROW_TOP, bis_pkg::OP_INSERT,     8'd0,   1'b0, none},
         '{ROW_REQ, bis_pkg::OP_MEMBER,     8'd5,   1'b1, status_of(0, 0,   0, 10,  0,   1, 1)},
         '{ROW_REQ, bis_pkg::OP_COMPLEMENT, 8'd0,   1'b1, status_of(0, 0,   0, 0,   0,   0, 0)},
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd0,   1'b1, status_of(1, 0,   0, 1,   0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_SUCCESSOR,  8'd0,   1'b1, status_of(1, 0,   0, 1,   0,   1, 0)},
         '{ROW_REQ, bis_pkg::OP_INSERT,     8'd1,   1'b1, status_of(0, 0,   0, 1,   0,   1, 1)},
         '{ROW_TOP, bis_pkg::OP_INSERT,     8'd255, 1'b0, none},
         '{ROW_REQ, bis_pkg::OP_REMOVE,     8'd0,   1'b0, none}
      };

      phase_tops = '{255, 1, 0, 37, 128, 254, 200, 100, 63, 255};
      phase_tops[7] = $urandom_range(2, 253);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_TOP)
            write_top(directed_rows[r].value);
         else
            send_request(directed_rows[r].op, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].status);
      end

      // Random phases. Some phases run one side without gaps; a few skip
      // the clear after the top changes so stale bits stay in the count.
      for (phase = 0; phase < 10; phase++) begin
         write_top(8'(phase_tops[phase]));
         send_gap_max = (phase % 3 == 1) ? 0 : 15;
         recv_gap_max = (phase % 4 == 2) ? 0 : 15;
         if (phase != 2 && phase != 6 && phase != 9)
            send_request(bis_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, none);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            // long hold-off on the response side while requests keep coming
            if (phase == 4 && k == 60) begin
               hold_pending = 1'b1;
               saved_gap = send_gap_max;
               send_gap_max = 0;
            end
            if (phase == 4 && k == 75) send_gap_max = saved_gap;
            // sender goes quiet until the block has drained
            if (phase == 3 && k == 70) wait_for_results();
            op = choose_op();
            send_request(op, choose_element(op), 1'b0, none);
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests at %0d top settings: insert %0d, remove %0d, member %0d,",
               op_count.sum(), top_writes, op_count[bis_pkg::OP_INSERT],
               op_count[bis_pkg::OP_REMOVE], op_count[bis_pkg::OP_MEMBER]);
      $display({"  successor %0d (%0d found), complement %0d, clear %0d, spare codes %0d,",
                " %0d range errors, %0d responses checked, %0d mismatches"},
               op_count[bis_pkg::OP_SUCCESSOR], successor_hits,
               op_count[bis_pkg::OP_COMPLEMENT], op_count[bis_pkg::OP_CLEAR],
               op_count[OP_SPARE_A] + op_count[OP_SPARE_B],
               range_errors_seen, responses_checked, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/bis_pkg.sv
src/bis_ctrl.sv
src/bis_datapath.sv
src/bitmap_integer_set.sv
src/bis_checker.sv
bench/tb.sv
